// File: rtl/particle_colour_gradient_unit_macros.svh
// Assertion helpers used by the RTL file that checks itself, pcg_queue.sv.
`ifndef PARTICLE_COLOUR_GRADIENT_UNIT_MACROS_SVH
`define PARTICLE_COLOUR_GRADIENT_UNIT_MACROS_SVH

// The condition holds at every clock edge out of reset.
`define PCG_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("pcg assertion failed");

// The antecedent at one edge implies the consequent at the same edge.
`define PCG_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcg assertion failed");

// The antecedent at one edge implies the consequent at the next edge.
`define PCG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcg assertion failed");

`endif

// File: rtl/pcg_pkg.sv
package pcg_pkg;

  localparam int NumStages  = 6;
  localparam int NumSegs    = 5;
  localparam int AgeW       = 13;
  localparam int TimeW      = 16;
  localparam int QuoBits    = 9;
  localparam int QueueDepth = 4;
  localparam int QPtrW      = 2;

  localparam logic [AgeW-1:0] OneQ12  = 13'd4096;
  localparam logic [2:0]      SegNone = 3'd5;

  typedef logic [47:0] stage_t;
  typedef logic [NumStages-1:0][47:0] stage_set_t;

  // One classified particle passed from the front end to the blender.
  typedef struct packed {
    logic [AgeW-1:0] age;
    logic [2:0]      seg;
    logic [31:0]     colour;
    logic            last;
  } word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic stage_t stage_of(stage_set_t s, logic [2:0] i);
    stage_t r;
    case (i)
      3'd0: r = s[0];
      3'd1: r = s[1];
      3'd2: r = s[2];
      3'd3: r = s[3];
      3'd4: r = s[4];
      default: r = s[NumStages-1];
    endcase
    return r;
  endfunction

endpackage

// File: rtl/particle_colour_gradient_unit.sv
// Channel   Handshake            Word contents
// input     in_valid / in_stall  time_left, life_total, in_red..in_alpha, is_last
// output    out_valid / out_stall out_red..out_alpha, segment, last_out
// config    wr_en (no wait)      wr_index selects stage 0..5, wr_data 48 bits
//
// Throughput is one word per cycle while the output is not stalled. A word
// accepted at one edge passes fifteen front stages, the first loaded on the
// accepting edge, one queue write, and fourteen blend stages to the output.
// The age divider retires one quotient bit per stage, and the channel dividers
// retire one bit per stage, which sets the pipeline depth.
// Synchronous reset clears all valid state and loads the default stage table.
// A stalled output freezes only the blender; the front keeps filling the
// four-word queue and stalls its input only once the queue is full.
module particle_colour_gradient_unit #(
  parameter int LIFE_WIDTH = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [2:0]            wr_index,
  input  logic [47:0]           wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [LIFE_WIDTH-1:0] time_left,
  input  logic [LIFE_WIDTH-1:0] life_total,
  input  logic [7:0]            in_red,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_blue,
  input  logic [7:0]            in_alpha,
  input  logic                  is_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic [7:0]            out_alpha,
  output logic [2:0]            segment,
  output logic                  last_out
);

  pcg_pkg::stage_set_t stages;
  pcg_pkg::word_t      fw;
  pcg_pkg::word_t      qw;
  pcg_pkg::q_status_t  qs;
  logic                push;
  logic                pop;

  // Stage table. Each entry holds a Q4.12 start time above an RGBA8 colour;
  // by default stage i starts at i+1 and is mid grey with zero alpha.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pcg_pkg::NumStages; i++) begin
        stages[i] <= {16'((i + 1) * 4096), 32'h8080_8000};
      end
    end else if (wr_en && (wr_index < 3'(pcg_pkg::NumStages))) begin
      stages[wr_index] <= wr_data;
    end
  end

  // The front end computes the particle age and picks the gradient segment.
  pcg_front #(
    .LIFE_WIDTH(LIFE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .time_left (time_left),
    .life_total(life_total),
    .colour    ({in_red, in_green, in_blue, in_alpha}),
    .is_last   (is_last),
    .stages    (stages),
    .qs        (qs),
    .push      (push),
    .word      (fw)
  );

  // A short queue decouples the two halves so each can stall on its own.
  pcg_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(fw),
    .pop  (pop),
    .rdata(qw),
    .qs   (qs)
  );

  // The back end blends the two stage colours and saturates each channel.
  pcg_back u_back (
    .clk      (clk),
    .rst      (rst),
    .word     (qw),
    .qs       (qs),
    .pop      (pop),
    .stages   (stages),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_red  (out_red),
    .out_green(out_green),
    .out_blue (out_blue),
    .out_alpha(out_alpha),
    .segment  (segment),
    .last_out (last_out)
  );

endmodule

// File: rtl/pcg_front.sv
module pcg_front #(
  parameter int LIFE_WIDTH = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [LIFE_WIDTH-1:0]  time_left,
  input  logic [LIFE_WIDTH-1:0]  life_total,
  input  logic [31:0]            colour,
  input  logic                   is_last,
  input  pcg_pkg::stage_set_t    stages,
  input  pcg_pkg::q_status_t     qs,
  output logic                   push,
  output pcg_pkg::word_t         word
);

  localparam int Last = pcg_pkg::AgeW + 1;

  logic [Last:0] vld;
  logic [LIFE_WIDTH:0]       rem [Last];
  logic [LIFE_WIDTH-1:0]     dvs [Last];
  logic [pcg_pkg::AgeW-1:0]  quo [Last];
  logic [Last-1:0]           zero;
  logic [Last-1:0]           neg;
  logic [31:0]               col [Last];
  logic [Last-1:0]           lst;
  logic                      en;

  assign en       = !(vld[Last] && qs.full);
  assign in_stall = !en;
  assign push     = vld[Last] && !qs.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      rem[0]  <= {1'b0, time_left};
      dvs[0]  <= life_total;
      quo[0]  <= '0;
      zero[0] <= (life_total == '0);
      // The quotient no longer fits the age divider once the remaining life
      // reaches twice the total; the age is then well below zero.
      neg[0]  <= ({1'b0, time_left} >= {life_total, 1'b0});
      col[0]  <= colour;
      lst[0]  <= is_last;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 1; k < Last; k++) begin : g_div
    localparam int B = pcg_pkg::AgeW - k;
    logic [LIFE_WIDTH:0]      trial;
    logic                     ge;
    logic [pcg_pkg::AgeW-1:0] qbit;
    assign trial = (k == 1) ? rem[k-1] : (rem[k-1] << 1);
    assign ge    = trial >= {1'b0, dvs[k-1]};
    assign qbit  = {{(pcg_pkg::AgeW-1){1'b0}}, ge} << B;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
      if (en) begin
        rem[k]    <= ge ? (trial - {1'b0, dvs[k-1]}) : trial;
        dvs[k]    <= dvs[k-1];
        quo[k]    <= quo[k-1] | qbit;
        zero[k]   <= zero[k-1];
        neg[k]    <= neg[k-1];
        col[k]    <= col[k-1];
        lst[k]    <= lst[k-1];
      end
    end
  end

  logic [pcg_pkg::AgeW-1:0] age;
  logic                     hit;
  logic [2:0]               seg;

  // A quotient above one makes the age negative, so no stage is reached.
  always_comb begin
    age = zero[Last-1] ? pcg_pkg::OneQ12 : (pcg_pkg::OneQ12 - quo[Last-1]);
    hit = zero[Last-1] || (!neg[Last-1] && (quo[Last-1] <= pcg_pkg::OneQ12));
    seg = pcg_pkg::SegNone;
    for (int j = 0; j < pcg_pkg::NumSegs; j++) begin
      if (hit && ({3'b0, age} >= stages[j][47:32])) begin
        seg = 3'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[Last] <= 1'b0;
    end else if (en) begin
      vld[Last] <= vld[Last-1];
    end
    if (en) begin
      word.age    <= age;
      word.seg    <= seg;
      word.colour <= col[Last-1];
      word.last   <= lst[Last-1];
    end
  end

endmodule

// File: rtl/pcg_queue.sv
`include "particle_colour_gradient_unit_macros.svh"

module pcg_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  pcg_pkg::word_t     wdata,
  input  logic               pop,
  output pcg_pkg::word_t     rdata,
  output pcg_pkg::q_status_t qs
);

  pcg_pkg::word_t mem [pcg_pkg::QueueDepth];
  logic [pcg_pkg::QPtrW-1:0] wr_ptr;
  logic [pcg_pkg::QPtrW-1:0] rd_ptr;
  logic [pcg_pkg::QPtrW:0]   count;

  assign qs.full  = (count == (pcg_pkg::QPtrW+1)'(pcg_pkg::QueueDepth));
  assign qs.empty = (count == '0);
  assign rdata    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  `PCG_ASSERT_ALWAYS(a_count_bound, count <= (pcg_pkg::QPtrW+1)'(pcg_pkg::QueueDepth))
  `PCG_ASSERT_IMPLIES(a_no_push_full, qs.full, !push)
  `PCG_ASSERT_IMPLIES(a_no_pop_empty, qs.empty, !pop)
  `PCG_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 1'b1)

endmodule

// File: rtl/pcg_back.sv
module pcg_back (
  input  logic                clk,
  input  logic                rst,
  input  pcg_pkg::word_t      word,
  input  pcg_pkg::q_status_t  qs,
  output logic                pop,
  input  pcg_pkg::stage_set_t stages,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_red,
  output logic [7:0]          out_green,
  output logic [7:0]          out_blue,
  output logic [7:0]          out_alpha,
  output logic [2:0]          segment,
  output logic                last_out
);

  localparam int SDiv0 = 4;
  localparam int SOut  = SDiv0 + pcg_pkg::QuoBits;
  localparam int QB    = pcg_pkg::QuoBits;

  typedef struct packed {
    logic [31:0] ca;
    logic [31:0] cb;
    logic [2:0]  seg;
    logic        last;
    logic        nohit;
    logic        dzero;
  } carry_t;

  logic [SOut:0] vld;
  carry_t        cr [SOut];
  logic          en;

  assign en        = !(vld[SOut] && out_stall);
  assign pop       = en && !qs.empty;
  assign out_valid = vld[SOut];

  // Stage 0: look up the two stage records and form interval terms.
  pcg_pkg::stage_t   st_s;
  pcg_pkg::stage_t   st_n;
  logic signed [16:0] den;
  logic               nohit;
  logic [31:0]        ca;

  always_comb begin
    st_s  = pcg_pkg::stage_of(stages, word.seg);
    st_n  = pcg_pkg::stage_of(stages, word.seg + 3'd1);
    den   = signed'({1'b0, st_n[47:32]}) - signed'({1'b0, st_s[47:32]});
    nohit = (word.seg == pcg_pkg::SegNone);
    ca    = nohit ? word.colour : st_s[31:0];
  end

  logic signed [8:0]  diff0 [4];
  logic [12:0]        numt0;
  logic [15:0]        dmag0;
  logic               dneg0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= pop;
    end
    if (en) begin
      cr[0].ca    <= ca;
      cr[0].cb    <= st_n[31:0];
      cr[0].seg   <= word.seg;
      cr[0].last  <= word.last;
      cr[0].nohit <= nohit;
      cr[0].dzero <= (den == '0);
      numt0       <= word.age - st_s[44:32];
      dneg0       <= den[16];
      dmag0       <= den[16] ? 16'(-den) : den[15:0];
      for (int c = 0; c < 4; c++) begin
        diff0[c] <= signed'({1'b0, st_n[31-8*c -: 8]}) - signed'({1'b0, ca[31-8*c -: 8]});
      end
    end
  end

  for (genvar s = 1; s < SOut; s++) begin : g_carry
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vld[s-1];
      end
      if (en) begin
        cr[s] <= cr[s-1];
      end
    end
  end

  // Stage 1: product of colour step and elapsed time, sign folded in.
  logic signed [22:0] prod1 [4];
  logic [15:0]        dmag1;
  // Stage 2: doubled numerator plus half-step bias.
  logic signed [23:0] nn2 [4];
  logic [15:0]        dmag2;

  always_ff @(posedge clk) begin
    if (en) begin
      dmag1 <= dmag0;
      dmag2 <= dmag1;
      for (int c = 0; c < 4; c++) begin
        prod1[c] <= dneg0 ? -(diff0[c] * signed'({1'b0, numt0}))
                          :  (diff0[c] * signed'({1'b0, numt0}));
        nn2[c]   <= (24'(prod1[c]) <<< 1) + signed'({8'b0, dmag1});
      end
    end
  end

  // Stage 3 and the nine divide steps.
  logic [23:0] rm  [QB+1][4];
  logic [8:0]  qq  [QB+1][4];
  logic [3:0]  sg  [QB+1];
  logic [3:0]  ov  [QB+1];
  logic [16:0] dv  [QB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0] <= {dmag2, 1'b0};
      for (int c = 0; c < 4; c++) begin
        rm[0][c] <= nn2[c][23] ? 24'(-nn2[c]) : nn2[c];
        qq[0][c] <= '0;
        sg[0][c] <= nn2[c][23];
        ov[0][c] <= {2'b0, (nn2[c][23] ? 24'(-nn2[c]) : nn2[c])} >= {dmag2, 10'b0};
      end
    end
  end

  for (genvar i = 1; i <= QB; i++) begin : g_qdiv
    localparam int B = QB - i;
    logic [25:0] thr;
    logic [3:0]  ge;
    logic [8:0]  qbit [4];
    assign thr = 26'(dv[i-1]) << B;
    always_comb begin
      for (int c = 0; c < 4; c++) begin
        ge[c]   = {2'b0, rm[i-1][c]} >= thr;
        qbit[c] = {8'b0, ge[c]} << B;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv[i] <= dv[i-1];
        sg[i] <= sg[i-1];
        ov[i] <= ov[i-1];
        for (int c = 0; c < 4; c++) begin
          rm[i][c] <= ge[c] ? 24'({2'b0, rm[i-1][c]} - thr) : rm[i-1][c];
          qq[i][c] <= qq[i-1][c] | qbit[c];
        end
      end
    end
  end

  // Output stage: floor correction, add base colour, saturate.
  logic [7:0]         res [4];
  logic [10:0]        mag;
  logic signed [10:0] qsig;
  logic signed [10:0] v;
  carry_t             cl;

  always_comb begin
    cl   = cr[SOut-1];
    mag  = '0;
    qsig = '0;
    v    = '0;
    for (int c = 0; c < 4; c++) begin
      mag  = {2'b0, qq[QB][c]} + 11'(rm[QB][c] != '0 && sg[QB][c]);
      qsig = sg[QB][c] ? -signed'(mag) : signed'(mag);
      v    = signed'({3'b0, cl.ca[31-8*c -: 8]}) + qsig;
      if (cl.nohit) begin
        res[c] = cl.ca[31-8*c -: 8];
      end else if (cl.dzero) begin
        res[c] = cl.cb[31-8*c -: 8];
      end else if (ov[QB][c]) begin
        res[c] = sg[QB][c] ? 8'd0 : 8'd255;
      end else if (v < 0) begin
        res[c] = 8'd0;
      end else if (v > 11'sd255) begin
        res[c] = 8'd255;
      end else begin
        res[c] = v[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[SOut] <= 1'b0;
    end else if (en) begin
      vld[SOut] <= vld[SOut-1];
    end
    if (en) begin
      out_red   <= res[0];
      out_green <= res[1];
      out_blue  <= res[2];
      out_alpha <= res[3];
      segment   <= cl.seg;
      last_out  <= cl.last;
    end
  end

endmodule

// File: dv/tb_particle_colour_gradient_unit.sv
`timescale 1ns / 1ps

// Scoreboard for the colour gradient unit. It keeps its own copy of the six
// stage registers and predicts the new colour and segment of every particle.
class gradient_scoreboard;
  logic [47:0] stages[6];
  logic [35:0] pending_colours[$];   // {r, g, b, a, segment, last}
  int          error_count;

  function new();
    error_count = 0;
    for (int i = 0; i < 6; i++) stages[i] = {16'((i + 1) * 4096), 32'h80808000};
  endfunction

  function void write_stage(logic [2:0] idx, logic [47:0] data);
    if (idx < 6) stages[idx] = data;
  endfunction

  // Works out the age, the segment and the blended colour of one particle.
  function void note_particle(logic [23:0] left, logic [23:0] total, logic [31:0] rgba,
                              logic last);
    longint age, num_t, den, a, b, n, d, v, q;
    int     seg;
    logic [7:0] chan[4];
    seg = -1;
    if (total == 0) age = 4096;
    else age = 4096 - longint'(({12'd0, left} << 12) / total);
    for (int j = 0; j < 5; j++)
      if (age >= longint'(stages[j][47:32])) seg = j;
    if (seg < 0) begin
      pending_colours.push_back({rgba, 3'd5, last});
      return;
    end
    num_t = age - longint'(stages[seg][47:32]);
    den = longint'(stages[seg + 1][47:32]) - longint'(stages[seg][47:32]);
    for (int c = 0; c < 4; c++) begin
      a = longint'(stages[seg][31 - 8 * c -: 8]);
      b = longint'(stages[seg + 1][31 - 8 * c -: 8]);
      if (den == 0) begin
        v = b;
      end else begin
        n = (b - a) * num_t;
        d = den;
        if (d < 0) begin
          d = -d;
          n = -n;
        end
        n = 2 * (a * d + n) + d;
        q = n / (2 * d);
        if ((n % (2 * d)) != 0 && n < 0) q--;
        v = q;
      end
      chan[c] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
    end
    pending_colours.push_back({chan[0], chan[1], chan[2], chan[3], 3'(seg), last});
  endfunction

  task report(string what, logic [35:0] got, logic [35:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    error_count++;
  endtask

  task check_colour(logic [35:0] got);
    logic [35:0] want;
    if (pending_colours.size() == 0) begin
      report("unexpected word", got, 'x);
      return;
    end
    want = pending_colours.pop_front();
    if (got[35:28] !== want[35:28]) report("red", got, want);
    if (got[27:20] !== want[27:20]) report("green", got, want);
    if (got[19:12] !== want[19:12]) report("blue", got, want);
    if (got[11:4] !== want[11:4]) report("alpha", got, want);
    if (got[3:1] !== want[3:1]) report("segment", got, want);
    if (got[0] !== want[0]) report("last", got, want);
  endtask
endclass

module tb_particle_colour_gradient_unit;
  logic        clk = 0;
  logic        rst = 1;
  logic        wr_en = 0;
  logic [2:0]  wr_index = 0;
  logic [47:0] wr_data = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [23:0] time_left = 0, life_total = 0;
  logic [7:0]  in_red = 0, in_green = 0, in_blue = 0, in_alpha = 0;
  logic        is_last = 0;
  logic        out_valid;
  logic        out_stall = 1;
  logic [7:0]  out_red, out_green, out_blue, out_alpha;
  logic [2:0]  segment;
  logic        last_out;

  gradient_scoreboard colour_board = new();
  int  idle_cycles;
  bit  hold_output;     // forces the receiver to hold off for a long stretch

  always #5 clk = ~clk;

  particle_colour_gradient_unit uut (.*);

  // Every edge where either channel moves a word resets the watchdog.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("tb_particle_colour_gradient_unit: errors");
      $finish;
    end
  end

  // Receiver: sometimes holds off for a random gap before taking each word, and stays
  // stalled for the whole of any long hold-off.
  initial begin
    int gap;
    @(posedge clk iff !rst);
    forever begin
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 9) < 3) gap = 0;
      if (gap != 0 || hold_output) begin
        out_stall <= 1;
        repeat (gap) @(posedge clk);
        while (hold_output) @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk iff out_valid);
      colour_board.check_colour({out_red, out_green, out_blue, out_alpha, segment,
                                 last_out});
    end
  end

  // Sends one particle; the word is noted once the block accepts it.
  task automatic send_particle(logic [23:0] left, logic [23:0] total, logic [31:0] rgba,
                               logic last, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    time_left <= left;
    life_total <= total;
    {in_red, in_green, in_blue, in_alpha} <= rgba;
    is_last <= last;
    @(posedge clk iff !in_stall);
    colour_board.note_particle(left, total, rgba, last);
  endtask

  // One write cycle, after which the task waits with wr_en low.
  task automatic write_stage(logic [2:0] idx, logic [47:0] data);
    wr_en <= 1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    wr_en <= 0;
    colour_board.write_stage(idx, data);
    @(posedge clk);
  endtask

  // Lets the pipeline drain before the stage table is touched again.
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (colour_board.pending_colours.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Random particle; ages are mostly sane, with some overdue and zero-life ones.
  task automatic random_particle(bit no_gap);
    logic [23:0] total, left;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      total = 24'($urandom_range(1, 5000));
      left = 24'($urandom_range(0, total));
    end else if (kind < 8) begin
      total = 24'($urandom);
      left = 24'($urandom);
    end else begin
      total = (kind == 8) ? 24'd0 : 24'($urandom_range(1, 100));
      left = 24'($urandom);
    end
    send_particle(left, total, $urandom, 1'($urandom_range(0, 1)), no_gap);
  endtask

  // Stage tables: two evenly spaced ordered tables, equal times, decreasing and
  // unordered times, the extremes of the register and a widely spread table.
  task automatic load_table(int pick);
    for (int i = 0; i < 6; i++) begin
      logic [15:0] t;
      case (pick)
        0: t = 16'(i * 800);
        1: t = 16'(i * 1024);
        2: t = (i < 3) ? 16'd2048 : 16'd4096;
        3: t = 16'(4096 - i * 700);
        4: t = 16'($urandom_range(0, 4500));
        5: t = (i == 0) ? 16'd0 : 16'hFFFF;
        default: t = 16'(i * 16'h3000);
      endcase
      write_stage(3'(i), {t, 32'($urandom)});
    end
  endtask

  initial begin
    hold_output = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed part with the reset table, then with a table that is reachable.
    send_particle(24'd0, 24'd0, 32'h01020304, 1, 0);
    send_particle(24'd10, 24'd5, 32'hFFFFFFFF, 0, 0);
    send_particle(24'hFFFFFF, 24'hFFFFFF, 32'h00000000, 1, 0);
    drain();
    write_stage(0, {16'd0, 32'h00FF00FF});
    write_stage(1, {16'd2048, 32'hFF00FF00});
    write_stage(2, {16'd2048, 32'h80808080});
    write_stage(3, {16'd3000, 32'h00000000});
    write_stage(4, {16'd2500, 32'hFFFFFFFF});
    write_stage(5, {16'hFFFF, 32'h12345678});
    write_stage(3'd6, 48'hFFFF_FFFF_FFFF);
    write_stage(3'd7, 48'h0);
    send_particle(24'd0, 24'd0, 32'h11223344, 0, 0);
    send_particle(24'd100, 24'd100, 32'h55667788, 0, 0);
    send_particle(24'd50, 24'd100, 32'h99AABBCC, 1, 0);
    send_particle(24'd0, 24'd100, 32'hDDEEFF00, 0, 0);
    send_particle(24'd101, 24'd100, 32'hFF00FF00, 1, 0);
    send_particle(24'hFFFFFF, 24'd1, 32'h00FF00FF, 0, 0);
    send_particle(24'd1, 24'hFFFFFF, 32'hFFFFFFFF, 1, 0);
    send_particle(24'd30, 24'd100, 32'h0F0F0F0F, 0, 0);
    send_particle(24'd5001, 24'd5000, 32'h13579BDF, 0, 0);
    drain();

    // Long output hold-off while the sender keeps offering words back to back.
    hold_output = 1;
    fork
      begin
        repeat (200) @(posedge clk);
        hold_output = 0;
      end
      repeat (60) random_particle(1);
    join
    drain();

    for (int phase = 0; phase < 7; phase++) begin
      load_table(phase);
      repeat (260) random_particle(phase == 2);
      drain();
    end

    if (colour_board.error_count == 0) $display("tb_particle_colour_gradient_unit: clean");
    else $display("tb_particle_colour_gradient_unit: errors");
    $finish;
  end
endmodule
